// File: rtl/mnhw_pkg.sv
package mnhw_pkg;

  // number of timestamp entries and the width of a node index
  localparam int MAX_NODES = 16;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = 5;
  localparam int TIME_W    = 32;
  localparam int ID_W      = 8;

  // result queue depth
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);

  typedef enum logic [1:0] {
    REQ_NONE      = 2'd0,
    REQ_CALIBRATE = 2'd1,
    REQ_READY     = 2'd2,
    REQ_FAILURE   = 2'd3
  } request_t;

  typedef enum logic [1:0] {
    CAUSE_NONE    = 2'd0,
    CAUSE_UNKNOWN = 2'd1,
    CAUSE_STARTUP = 2'd2,
    CAUSE_CHECKIN = 2'd3
  } cause_t;

  typedef enum logic [1:0] {
    PH_STARTUP = 2'd0,
    PH_RUNNING = 2'd1,
    PH_FAILED  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    REG_NODE_COUNT      = 2'd0,
    REG_STARTUP_TIMEOUT = 2'd1,
    REG_CHECKIN_TIMEOUT = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // input kind codes
  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_CHECKIN = 1'b1;

  // one result item
  typedef struct packed {
    logic     last;
    phase_t   phase;
    logic [ID_W-1:0] culprit;
    cause_t   cause;
    request_t request;
  } result_t;

endpackage

// File: rtl/mnhw_res_fifo.sv
module mnhw_res_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push0,
  input  mnhw_pkg::result_t data0,
  input  logic              push1,
  input  mnhw_pkg::result_t data1,
  output logic              room2,
  output logic              out_valid,
  input  logic              out_ready,
  output mnhw_pkg::result_t out_item
);
  import mnhw_pkg::*;

  result_t                entries [RES_DEPTH];
  logic [RES_PTR_W-1:0]   wr_ptr;
  logic [RES_PTR_W-1:0]   rd_ptr;
  logic [RES_PTR_W:0]     count;
  logic [RES_PTR_W:0]     count_next;
  logic [RES_PTR_W-1:0]   wr_ptr_next;
  logic                   pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_item  = entries[rd_ptr];
  assign room2     = (count <= (RES_PTR_W+1)'(RES_DEPTH - 2));

  // up to two pushes and one pop per cycle
  always_comb begin
    wr_ptr_next = wr_ptr + RES_PTR_W'(push0) + RES_PTR_W'(push1);
    count_next  = count + (RES_PTR_W+1)'(push0) + (RES_PTR_W+1)'(push1)
                  - (RES_PTR_W+1)'(pop);
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + RES_PTR_W'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push0) begin
      entries[wr_ptr] <= data0;
    end
    if (push1) begin
      entries[wr_ptr + RES_PTR_W'(1)] <= data1;
    end
  end

endmodule

// File: rtl/multi_node_heartbeat_watchdog.sv
// check-in, or tick outside the running phase: result pushed into the result
// buffer on accept; running tick: result after a scan of the monitored nodes
// through the timestamp memory's read port, which a failing node ends early
// throughput: no new item is taken during a running tick's scan; other items
// every cycle while the 4-entry result buffer has room for two
// sync reset: startup phase, tick count and seen mask cleared, default config
module multi_node_heartbeat_watchdog (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] node_id
  input  logic        s_tuser,   // [0] kind
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [1:0] request, [3:2] cause, [11:4] culprit,
                                 // [13:12] phase, [15:14] zero
  output logic        m_tlast,   // last
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import mnhw_pkg::*;

  // configuration
  logic [CNT_W-1:0]  node_count;
  logic [TIME_W-1:0] startup_timeout;
  logic [TIME_W-1:0] checkin_timeout;

  // control state
  state_t               state, state_next;
  phase_t               mode, mode_next;
  logic [TIME_W-1:0]    tick_count, tick_next;
  logic [MAX_NODES-1:0] seen_mask, seen_next;
  logic [CNT_W-1:0]     scan_idx, scan_idx_next;
  logic                 rd_valid, rd_valid_next;
  logic [NODE_W-1:0]    rd_node, rd_node_next;

  // timestamp memory
  logic [TIME_W-1:0] last_seen_time [MAX_NODES];
  logic [TIME_W-1:0] rd_data;
  logic [NODE_W-1:0] rd_addr;
  logic              mem_we;
  logic [NODE_W-1:0] mem_waddr;

  // result queue interface
  logic    push0, push1, room2;
  result_t res0, res1, out_item;

  logic                 in_fire;
  logic [CNT_W-1:0]     n_live;
  logic [MAX_NODES-1:0] want_mask;
  logic [NODE_W-1:0]    unseen_idx;
  logic [TIME_W-1:0]    tick_inc, tick_eff, age;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE) && room2;
  assign in_fire   = s_tvalid && s_tready;

  // configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count      <= CNT_W'(1);
      startup_timeout <= TIME_W'(1000);
      checkin_timeout <= TIME_W'(100);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NODE_COUNT:      node_count      <= cfg_data[CNT_W-1:0];
        REG_STARTUP_TIMEOUT: startup_timeout <= cfg_data;
        REG_CHECKIN_TIMEOUT: checkin_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  // live node count clamped to 1..MAX_NODES, and its mask
  always_comb begin
    if (node_count == '0) begin
      n_live = CNT_W'(1);
    end else if (node_count > CNT_W'(MAX_NODES)) begin
      n_live = CNT_W'(MAX_NODES);
    end else begin
      n_live = node_count;
    end
    for (int i = 0; i < MAX_NODES; i++) begin
      want_mask[i] = (CNT_W'(i) < n_live);
    end
  end

  // lowest monitored node not yet seen, zero if none
  always_comb begin
    unseen_idx = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (want_mask[i] && !seen_mask[i]) begin
        unseen_idx = NODE_W'(i);
      end
    end
  end

  assign tick_inc = tick_count + TIME_W'(1);
  assign tick_eff = (s_tuser == KIND_TICK) ? tick_inc : tick_count;
  assign age      = tick_count - rd_data;

  // sequencer: next state and result pushes
  always_comb begin
    state_next    = state;
    mode_next     = mode;
    tick_next     = tick_count;
    seen_next     = seen_mask;
    scan_idx_next = scan_idx;
    rd_valid_next = 1'b0;
    rd_node_next  = rd_node;
    rd_addr       = scan_idx[NODE_W-1:0];
    mem_we        = 1'b0;
    mem_waddr     = s_tdata[NODE_W-1:0];
    push0         = 1'b0;
    push1         = 1'b0;
    res0          = '{last: 1'b1, phase: mode, culprit: '0,
                      cause: CAUSE_NONE, request: REQ_NONE};
    res1          = '{last: 1'b1, phase: PH_RUNNING, culprit: '0,
                      cause: CAUSE_NONE, request: REQ_READY};
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (mode == PH_FAILED) begin
            push0 = 1'b1;
          end else begin
            tick_next = tick_eff;
            if (mode == PH_STARTUP && tick_eff >= startup_timeout) begin
              // startup deadline reached
              mode_next     = PH_FAILED;
              push0         = 1'b1;
              res0.phase    = PH_FAILED;
              res0.request  = REQ_FAILURE;
              res0.cause    = CAUSE_STARTUP;
              res0.culprit  = ID_W'(unseen_idx);
            end else if (s_tuser == KIND_TICK) begin
              if (mode == PH_RUNNING) begin
                state_next    = ST_SCAN;
                scan_idx_next = '0;
              end else begin
                push0 = 1'b1;
              end
            end else if (s_tdata >= ID_W'(n_live)) begin
              // check-in from an unknown node
              mode_next     = PH_FAILED;
              push0         = 1'b1;
              res0.phase    = PH_FAILED;
              res0.request  = REQ_FAILURE;
              res0.cause    = CAUSE_UNKNOWN;
              res0.culprit  = s_tdata;
            end else begin
              // valid check-in: store time and mark seen
              mem_we = 1'b1;
              seen_next = seen_mask | (MAX_NODES'(1) << s_tdata[NODE_W-1:0]);
              push0  = 1'b1;
              if (mode == PH_STARTUP && (seen_next & want_mask) == want_mask) begin
                mode_next    = PH_RUNNING;
                push1        = 1'b1;
                res0.phase   = PH_RUNNING;
                res0.request = REQ_CALIBRATE;
                res0.last    = 1'b0;
              end
            end
          end
        end
      end
      ST_SCAN: begin
        // issue one read per cycle over the monitored nodes
        if (scan_idx < n_live) begin
          rd_valid_next = 1'b1;
          rd_node_next  = scan_idx[NODE_W-1:0];
          scan_idx_next = scan_idx + CNT_W'(1);
        end
        // compare the entry read in the previous cycle
        if (rd_valid) begin
          if (age > checkin_timeout) begin
            mode_next     = PH_FAILED;
            state_next    = ST_IDLE;
            rd_valid_next = 1'b0;
            push0         = 1'b1;
            res0.phase    = PH_FAILED;
            res0.request  = REQ_FAILURE;
            res0.cause    = CAUSE_CHECKIN;
            res0.culprit  = ID_W'(rd_node);
          end else if (CNT_W'(rd_node) == n_live - CNT_W'(1)) begin
            state_next    = ST_IDLE;
            rd_valid_next = 1'b0;
            push0         = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      mode       <= PH_STARTUP;
      tick_count <= '0;
      seen_mask  <= '0;
      scan_idx   <= '0;
      rd_valid   <= 1'b0;
      rd_node    <= '0;
    end else begin
      state      <= state_next;
      mode       <= mode_next;
      tick_count <= tick_next;
      seen_mask  <= seen_next;
      scan_idx   <= scan_idx_next;
      rd_valid   <= rd_valid_next;
      rd_node    <= rd_node_next;
    end
  end

  // timestamp memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      last_seen_time[mem_waddr] <= tick_count;
    end
    rd_data <= last_seen_time[rd_addr];
  end

  mnhw_res_fifo u_res_fifo (
    .clk       (clk),
    .rst       (rst),
    .push0     (push0),
    .data0     (res0),
    .push1     (push1),
    .data1     (res1),
    .room2     (room2),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (out_item)
  );

  // pack the result item
  assign m_tdata = {2'b00, out_item.phase, out_item.culprit,
                    out_item.cause, out_item.request};
  assign m_tlast = out_item.last;

endmodule

// File: rtl/mnhw_checker.sv
module mnhw_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast
);
  import mnhw_pkg::*;

  logic out_fire;
  logic saw_fail;

  assign out_fire = m_tvalid && m_tready;

  // remember that a failed phase has been reported
  always_ff @(posedge clk) begin
    if (rst) begin
      saw_fail <= 1'b0;
    end else if (out_fire && m_tdata[13:12] == PH_FAILED) begin
      saw_fail <= 1'b1;
    end
  end

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // failure is terminal: later items report nothing in failed phase
  a_terminal: assert property (@(posedge clk) disable iff (rst)
    out_fire && saw_fail |-> m_tdata[13:12] == PH_FAILED && m_tdata[1:0] == REQ_NONE)
    else $error("activity after failure");

  // a failure request ends its item and enters the failed phase with a cause
  a_failure: assert property (@(posedge clk) disable iff (rst)
    out_fire && m_tdata[1:0] == REQ_FAILURE |->
      m_tlast && m_tdata[13:12] == PH_FAILED && m_tdata[3:2] != CAUSE_NONE)
    else $error("malformed failure result");

  // calibrate does not end its item and carries the running phase
  a_calibrate: assert property (@(posedge clk) disable iff (rst)
    out_fire && m_tdata[1:0] == REQ_CALIBRATE |->
      !m_tlast && m_tdata[13:12] == PH_RUNNING)
    else $error("calibrate result malformed");

  // no cause means no culprit
  a_culprit: assert property (@(posedge clk) disable iff (rst)
    out_fire && m_tdata[3:2] == CAUSE_NONE |-> m_tdata[11:4] == 8'd0)
    else $error("culprit without cause");

endmodule

bind multi_node_heartbeat_watchdog mnhw_checker u_mnhw_checker (.*);

// File: verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mnhw_pkg::*;

  // cycles to let pass after the last result before touching registers
  localparam int SETTLE      = 24;
  // length of the long receiver hold-off
  localparam int HOLD_CYCLES = 300;

  // predicts watchdog results and checks them in arrival order
  class heartbeat_scoreboard;
    logic [4:0]           node_count;
    logic [31:0]          startup_limit;
    logic [31:0]          checkin_limit;
    phase_t               mode;
    logic [31:0]          ticks;
    logic [MAX_NODES-1:0] seen;
    logic [31:0]          stamp [MAX_NODES];
    result_t              pending_results [$];
    int                   errors;

    function new();
      node_count    = 5'd1;
      startup_limit = 32'd1000;
      checkin_limit = 32'd100;
      mode          = PH_STARTUP;
      ticks         = '0;
      seen          = '0;
      errors        = 0;
      foreach (stamp[i]) stamp[i] = '0;
    endfunction

    // zero counts as one node, anything above the table size as a full table
    function int live_count();
      if (node_count == 5'd0) return 1;
      if (node_count > MAX_NODES) return MAX_NODES;
      return int'(node_count);
    endfunction

    function void note_config(cfg_reg_t idx, logic [31:0] val);
      case (idx)
        REG_NODE_COUNT:      node_count = val[4:0];
        REG_STARTUP_TIMEOUT: startup_limit = val;
        REG_CHECKIN_TIMEOUT: checkin_limit = val;
        default: ;
      endcase
    endfunction

    function void add_result(request_t req, cause_t why, logic [7:0] culprit, logic last);
      result_t r;
      r.request = req;
      r.cause   = why;
      r.culprit = culprit;
      r.phase   = mode;
      r.last    = last;
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void predict_item(logic kind, logic [7:0] id);
      int          n;
      logic [7:0]  lowest;
      bit          all_seen;
      logic [31:0] age;
      n = live_count();
      // failed is terminal, nothing is counted any more
      if (mode == PH_FAILED) begin
        add_result(REQ_NONE, CAUSE_NONE, 8'd0, 1'b1);
        return;
      end
      if (kind == KIND_TICK) ticks = ticks + 32'd1;
      // startup deadline goes first, check-ins included
      if (mode == PH_STARTUP && ticks >= startup_limit) begin
        lowest = 8'd0;
        for (int i = n - 1; i >= 0; i--)
          if (!seen[i]) lowest = 8'(i);
        mode = PH_FAILED;
        add_result(REQ_FAILURE, CAUSE_STARTUP, lowest, 1'b1);
        return;
      end
      // running tick: lowest node whose age is over the limit
      if (kind == KIND_TICK) begin
        if (mode == PH_RUNNING) begin
          for (int i = 0; i < n; i++) begin
            age = ticks - stamp[i];
            if (age > checkin_limit) begin
              mode = PH_FAILED;
              add_result(REQ_FAILURE, CAUSE_CHECKIN, 8'(i), 1'b1);
              return;
            end
          end
        end
        add_result(REQ_NONE, CAUSE_NONE, 8'd0, 1'b1);
        return;
      end
      if (id >= n) begin
        mode = PH_FAILED;
        add_result(REQ_FAILURE, CAUSE_UNKNOWN, id, 1'b1);
        return;
      end
      stamp[id] = ticks;
      seen[id]  = 1'b1;
      // last missing node completes startup
      if (mode == PH_STARTUP) begin
        all_seen = 1'b1;
        for (int i = 0; i < n; i++)
          if (!seen[i]) all_seen = 1'b0;
        if (all_seen) begin
          mode = PH_RUNNING;
          add_result(REQ_CALIBRATE, CAUSE_NONE, 8'd0, 1'b0);
          add_result(REQ_READY, CAUSE_NONE, 8'd0, 1'b1);
          return;
        end
      end
      add_result(REQ_NONE, CAUSE_NONE, 8'd0, 1'b1);
    endfunction

    // node that the next tick would fail on, or -1
    function int overdue_node();
      logic [31:0] age;
      for (int i = 0; i < live_count(); i++) begin
        age = ticks + 32'd1 - stamp[i];
        if (age > checkin_limit) return i;
      end
      return -1;
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("ERROR %s: got %0d, want %0d", field, got, want);
    endtask

    task check_result(logic [15:0] data, logic last);
      result_t want;
      if (pending_results.size() == 0) begin
        report("result with nothing pending, data", data, 32'd0);
        return;
      end
      want = pending_results.pop_front();
      if (data[1:0] !== want.request) report("request", data[1:0], want.request);
      if (data[3:2] !== want.cause) report("cause", data[3:2], want.cause);
      if (data[11:4] !== want.culprit) report("culprit", data[11:4], want.culprit);
      if (data[13:12] !== want.phase) report("phase", data[13:12], want.phase);
      if (data[15:14] !== 2'b00) report("padding", data[15:14], 32'd0);
      if (last !== want.last) report("last", last, want.last);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  bit hold_req = 1'b0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;

  heartbeat_scoreboard sb = new();

  multi_node_heartbeat_watchdog i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stalls, bursts, and one long hold-off on request
  initial begin : result_sink
    int gap;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(negedge clk);
        hold_req = 1'b0;
      end
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      sb.check_result(m_tdata, m_tlast);
    end
  end

  // offer one item after a random gap and wait for it to be taken
  task automatic send_item(logic kind, logic [7:0] id);
    int gap;
    if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= id;
    do @(posedge clk); while (s_tready !== 1'b1);
    sb.predict_item(kind, id);
  endtask

  // stop offering and wait until every result is back
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.note_config(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // startup traffic that never checks in the held-back node
  task automatic startup_traffic(int count, int hold);
    int n;
    int id;
    n = sb.live_count();
    repeat (count) begin
      if ($urandom_range(0, 9) < 3) begin
        send_item(KIND_TICK, 8'($urandom));
      end else begin
        do id = $urandom_range(0, n - 1); while (id == hold);
        send_item(KIND_CHECKIN, 8'(id));
      end
    end
  endtask

  // running traffic that keeps every node inside its check-in window
  task automatic running_traffic(int count);
    int id;
    repeat (count) begin
      id = sb.overdue_node();
      if (id >= 0)
        send_item(KIND_CHECKIN, 8'(id));
      else if ($urandom_range(0, 1) == 0)
        send_item(KIND_TICK, 8'($urandom));
      else
        send_item(KIND_CHECKIN, 8'($urandom_range(0, sb.live_count() - 1)));
    end
  endtask

  initial begin : stimulus
    int first_count;
    int hold;
    int live;
    int id;
    int sel;
    bit startup_fail;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = 8'd0;
    s_tuser   = KIND_TICK;
    cfg_valid = 1'b0;
    cfg_index = REG_NODE_COUNT;
    cfg_data  = 32'd0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // one tick under the reset configuration
    send_item(KIND_TICK, 8'd0);
    drain();
    write_reg(REG_NODE_COUNT, 32'd31);
    write_reg(REG_STARTUP_TIMEOUT, 32'hFFFF_FFFF);
    write_reg(REG_CHECKIN_TIMEOUT, 32'hFFFF_FFFF);

    // first and last node, a repeated check-in, ticks in between
    send_item(KIND_CHECKIN, 8'd0);
    send_item(KIND_CHECKIN, 8'd15);
    send_item(KIND_TICK, 8'hFF);
    send_item(KIND_CHECKIN, 8'd15);
    send_item(KIND_CHECKIN, 8'd5);
    send_item(KIND_TICK, 8'd0);
    send_item(KIND_TICK, 8'd0);
    drain();

    // pick the node set and hold one unseen node back so startup lingers
    first_count = $urandom_range(0, 1) ? 16 : $urandom_range(2, 16);
    write_reg(REG_NODE_COUNT, first_count == 16 ? $urandom_range(16, 31) : first_count);
    do hold = $urandom_range(0, first_count - 1); while (sb.seen[hold]);
    startup_fail = ($urandom_range(0, 3) == 0);

    // long receiver hold-off while items keep coming
    hold_req = 1'b1;
    tx_burst = 1'b1;
    startup_traffic(startup_fail ? 1400 : 400, hold);
    drain();

    if (startup_fail) begin
      // deadline at or just past the current count; a check-in may trip it too
      write_reg(REG_STARTUP_TIMEOUT, sb.ticks + $urandom_range(0, 2));
      while (sb.mode != PH_FAILED) startup_traffic(1, hold);
    end else begin
      // held-back node completes startup: calibrate then ready
      send_item(KIND_CHECKIN, 8'(hold));
      drain();
      write_reg(REG_STARTUP_TIMEOUT, 32'd1);
      write_reg(REG_CHECKIN_TIMEOUT, $urandom_range(10, 60));
      for (int chunk = 0; chunk < 14; chunk++) begin
        running_traffic(80);
        drain();
        // node count stays within the nodes seen during startup
        sel = (chunk == 3) ? 5 : (chunk == 4) ? 6 : $urandom_range(0, 4);
        case (sel)
          0: write_reg(REG_NODE_COUNT, $urandom_range(0, 1));
          1: write_reg(REG_NODE_COUNT,
                       first_count == 16 ? $urandom_range(16, 31) : first_count);
          2: write_reg(REG_NODE_COUNT, $urandom_range(1, first_count));
          3: write_reg(REG_CHECKIN_TIMEOUT, $urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
          5: write_reg(REG_CHECKIN_TIMEOUT, 32'd1);
          6: write_reg(REG_NODE_COUNT, 32'd0);
          default: write_reg(REG_CHECKIN_TIMEOUT, $urandom_range(2, 80));
        endcase
      end

      if ($urandom_range(0, 1) == 0) begin
        // unknown node ends the run
        live = sb.live_count();
        case ($urandom_range(0, 2))
          0: id = live;
          1: id = 255;
          default: id = $urandom_range(live, 255);
        endcase
        send_item(KIND_CHECKIN, 8'(id));
      end else begin
        // tight window, a check-in that tests no age, then ticks until one node ages out
        write_reg(REG_CHECKIN_TIMEOUT, $urandom_range(1, 4));
        send_item(KIND_CHECKIN, 8'($urandom_range(0, sb.live_count() - 1)));
        while (sb.mode != PH_FAILED) send_item(KIND_TICK, 8'($urandom));
      end
    end

    // failed phase ignores everything, any node number
    repeat (40) send_item(1'($urandom_range(0, 1)), 8'($urandom));
    drain();

    if (sb.errors == 0) begin
      $display("PASS multi_node_heartbeat_watchdog");
    end else begin
      $display("FAIL multi_node_heartbeat_watchdog");
    end
    $finish;
  end

  // hang guard
  initial begin : run_limit
    #5_000_000;
    $display("FAIL multi_node_heartbeat_watchdog");
    $finish;
  end

endmodule
